[hw/rtl/wsa_pkg.sv]
package wsa_pkg;

    // Result status codes.
    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_MISMATCH  = 3'd1,
        ST_ZERO_ERR  = 3'd2,
        ST_ZERO_TSYS = 3'd3,
        ST_SKIPPED   = 3'd4
    } status_t;

    // Weighting modes held in the mode register.
    localparam logic [2:0] MODE_SUM   = 3'd0;
    localparam logic [2:0] MODE_EQUAL = 3'd1;
    localparam logic [2:0] MODE_RMS   = 3'd2;
    localparam logic [2:0] MODE_TSYS  = 3'd3;
    localparam logic [2:0] MODE_TIME  = 3'd4;
    localparam logic [2:0] MODE_ERROR = 3'd5;

    // Unsigned Q1.30 constants.
    localparam logic [30:0] Q30_ONE  = 31'h4000_0000;
    localparam logic [30:0] Q30_HALF = 31'h2000_0000;

    // One accepted item after classification in the front end.
    typedef struct packed {
        logic               start_new;
        logic        [11:0] channel;
        logic signed [31:0] sample_value;
        logic        [31:0] sample_error;
        logic        [12:0] scan_channels;
        logic        [31:0] scan_tsys;
        logic        [31:0] scan_int_time;
        logic        [31:0] scan_sigma;
        logic        [31:0] acc_sigma;
        logic               last;
        logic               outside;
        logic        [15:0] idx;
    } item_t;

    typedef enum logic {
        ITU_DIV,
        ITU_SQRT
    } itu_op_t;

    typedef struct packed {
        logic        start;
        itu_op_t     op;
        logic [63:0] arg;
        logic [32:0] divisor;
    } itu_req_t;

    typedef struct packed {
        logic        done;
        logic [31:0] result;
    } itu_rsp_t;

    typedef enum logic [1:0] {
        PH_ERR,
        PH_TOLD,
        PH_TNEW
    } phase_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_READ,
        S_CHECK,
        S_SQA,
        S_SQB,
        S_SQC,
        S_TSH,
        S_T3A,
        S_T3B,
        S_T3C,
        S_T3D,
        S_T3E,
        S_NORM,
        S_DIV,
        S_DIVW,
        S_BLEND,
        S_BLEND2,
        S_MSQ,
        S_MS0,
        S_MS1,
        S_MS2,
        S_MS3,
        S_ROOT,
        S_ROOTW,
        S_OUT
    } back_state_t;

endpackage

[hw/rtl/wsa_front.sv]
module wsa_front
    import wsa_pkg::*;
#(
    parameter int CHANNELS = 4096
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [223:0] s_axis_tdata,
    input  logic [0:0]   s_axis_tuser,
    output logic         q_valid,
    input  logic         q_ready,
    output item_t        q_item
);

    localparam int DEPTH = 2;

    item_t      mem_reg [DEPTH];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] cnt_reg;
    logic [1:0] cnt_next;
    logic       push;
    logic       pop;
    item_t      item_in;

    // Reduce the channel number modulo the store depth by binary
    // compare and subtract; the quotient has at most eight bits.
    function automatic logic [11:0] wrap_channel(input logic [11:0] ch);
        logic [11:0] r;
        logic [31:0] lim;
        r = ch;
        for (int k = 7; k >= 0; k--)
        begin
            lim = 32'(CHANNELS) << k;
            if (32'(r) >= lim)
            begin
                r = r - lim[11:0];
            end
        end
        return r;
    endfunction

    always_comb
    begin
        item_in.start_new     = s_axis_tuser[0];
        item_in.channel       = s_axis_tdata[11:0];
        item_in.sample_value  = s_axis_tdata[43:12];
        item_in.sample_error  = s_axis_tdata[75:44];
        item_in.scan_channels = s_axis_tdata[88:76];
        item_in.scan_tsys     = s_axis_tdata[120:89];
        item_in.scan_int_time = s_axis_tdata[152:121];
        item_in.scan_sigma    = s_axis_tdata[184:153];
        item_in.acc_sigma     = s_axis_tdata[216:185];
        item_in.last          = ({1'b0, s_axis_tdata[11:0]} + 13'd1) == s_axis_tdata[88:76];
        item_in.outside       = {1'b0, s_axis_tdata[11:0]} >= s_axis_tdata[88:76];
        item_in.idx           = 16'(wrap_channel(s_axis_tdata[11:0]));
    end

    assign s_axis_tready = (cnt_reg != 2'(DEPTH));
    assign q_valid       = (cnt_reg != 2'd0);
    assign q_item        = mem_reg[rd_ptr_reg];
    assign push          = s_axis_tvalid && s_axis_tready;
    assign pop           = q_valid && q_ready;

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= item_in;
        end
    end

endmodule

[hw/rtl/wsa_itu.sv]
module wsa_itu
    import wsa_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  itu_req_t req,
    output itu_rsp_t rsp
);

    logic        busy_reg;
    logic        done_reg;
    itu_op_t     op_reg;
    logic [5:0]  cnt_reg;
    logic [35:0] rem_reg;
    logic [63:0] src_reg;
    logic [31:0] res_reg;
    logic [32:0] div_reg;
    logic [36:0] r2;
    logic [36:0] trial;
    logic        ge;

    // One quotient bit or one root bit per cycle.
    always_comb
    begin
        if (op_reg == ITU_DIV)
        begin
            r2    = {1'b0, rem_reg[34:0], src_reg[63]};
            trial = {4'd0, div_reg};
        end
        else
        begin
            r2    = {rem_reg[34:0], src_reg[63:62]};
            trial = {3'd0, res_reg, 2'b01};
        end
        ge = (r2 >= trial);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 6'd0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= (req.op == ITU_DIV) ? 6'd31 : 6'd32;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 6'd1;
                if (cnt_reg == 6'd1)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            op_reg  <= req.op;
            div_reg <= req.divisor;
            res_reg <= 32'd0;
            if (req.op == ITU_DIV)
            begin
                rem_reg <= {5'd0, req.arg[61:31]};
                src_reg <= {req.arg[30:0], 33'd0};
            end
            else
            begin
                rem_reg <= 36'd0;
                src_reg <= req.arg;
            end
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? 36'(r2 - trial) : r2[35:0];
            src_reg <= (op_reg == ITU_DIV) ? (src_reg << 1) : (src_reg << 2);
            res_reg <= {res_reg[30:0], ge};
        end
    end

    assign rsp.done   = done_reg;
    assign rsp.result = res_reg;

endmodule

[hw/rtl/wsa_back.sv]
module wsa_back
    import wsa_pkg::*;
#(
    parameter int CHANNELS = 4096
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic [2:0]   avg_mode,
    input  logic         q_valid,
    output logic         q_ready,
    input  item_t        q_item,
    output itu_req_t     itu_req,
    input  itu_rsp_t     itu_rsp,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [159:0] m_axis_tdata,
    output logic [2:0]   m_axis_tuser,
    output logic         m_axis_tlast
);

    localparam int IDX_W = $clog2(CHANNELS);

    logic [31:0] avg_mem [CHANNELS];
    logic [31:0] err_mem [CHANNELS];

    back_state_t state_reg, state_next;
    item_t       it_reg, it_next;
    logic [31:0] rd_av_reg, rd_er_reg;
    logic [31:0] old_reg, old_next;
    logic [31:0] eo_reg, eo_next;
    logic [63:0] a_reg, a_next;
    logic [63:0] b_reg, b_next;
    logic [30:0] f_reg, f_next;
    logic [31:0] to_reg, to_next;
    logic [31:0] tn_reg, tn_next;
    logic [63:0] prod_reg;
    logic [63:0] p_reg, p_next;
    logic [63:0] acc_reg, acc_next;
    phase_t      phase_reg, phase_next;
    logic [31:0] vout_reg, vout_next;
    logic [31:0] eout_reg, eout_next;
    status_t     status_reg, status_next;
    logic        done_reg, done_next;
    logic [12:0] cnt_ch_reg, cnt_ch_next;
    logic [31:0] tsys_reg, tsys_next;
    logic [31:0] time_reg, time_next;
    logic [15:0] count_reg, count_next;
    logic        skip_reg, skip_next;
    logic        m_valid_reg, m_valid_next;
    logic [159:0] m_data_reg, m_data_next;
    logic [2:0]  m_user_reg, m_user_next;
    logic        m_last_reg, m_last_next;

    logic [IDX_W-1:0] addr;
    logic        av_we, er_we;
    logic [31:0] av_wd, er_wd;
    logic [31:0] mul_a, mul_b;
    logic        out_free;
    logic [63:0] ab_or;
    logic [32:0] wsum;
    logic signed [32:0] diff;
    logic [31:0] mag;
    logic signed [32:0] sat_sum;
    logic [32:0] rnd;
    logic [33:0] blend_val;
    logic [30:0] g;
    logic [31:0] sq_x;
    logic [32:0] tt;
    status_t     chk_status;

    assign addr     = it_reg.idx[IDX_W-1:0];
    assign out_free = !m_valid_reg || m_axis_tready;
    assign ab_or    = a_reg | b_reg;
    assign wsum     = a_reg[32:0] + b_reg[32:0];
    assign diff     = 33'(it_reg.sample_value) - 33'($signed(old_reg));
    assign mag      = diff[32] ? 32'(-diff) : diff[31:0];
    assign sat_sum  = 33'(it_reg.sample_value) + 33'($signed(old_reg));
    assign rnd      = 33'((prod_reg + 64'h2000_0000) >> 30);
    assign blend_val = diff[32] ? (34'($signed(old_reg)) - 34'(rnd))
                                : (34'($signed(old_reg)) + 34'(rnd));
    assign g        = (phase_reg == PH_TNEW) ? f_reg : (Q30_ONE - f_reg);
    assign tt       = 33'(time_reg) + 33'(it_reg.scan_int_time);

    always_comb
    begin
        case (phase_reg)
            PH_ERR:  sq_x = eo_reg;
            PH_TOLD: sq_x = tsys_reg;
            default: sq_x = it_reg.scan_tsys;
        endcase
    end

    // Classification of a regular item against the scan registers and the stored error.
    always_comb
    begin
        chk_status = ST_OK;
        if (it_reg.scan_channels != cnt_ch_reg)
        begin
            chk_status = ST_MISMATCH;
        end
        else if (avg_mode == MODE_RMS && (it_reg.acc_sigma == 32'd0 || it_reg.scan_sigma == 32'd0))
        begin
            chk_status = ST_ZERO_ERR;
        end
        else if (avg_mode == MODE_TSYS && (tsys_reg == 32'd0 || it_reg.scan_tsys == 32'd0))
        begin
            chk_status = ST_ZERO_TSYS;
        end
        else if (avg_mode == MODE_ERROR && (rd_er_reg == 32'd0 || it_reg.sample_error == 32'd0))
        begin
            chk_status = ST_ZERO_ERR;
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:   if (q_valid) state_next = S_READ;
            S_READ:   state_next = S_CHECK;
            S_CHECK:
            begin
                if (it_reg.outside || it_reg.start_new || skip_reg || chk_status != ST_OK)
                begin
                    state_next = S_OUT;
                end
                else
                begin
                    case (avg_mode) inside
                        MODE_SUM:               state_next = S_BLEND;
                        MODE_RMS, MODE_ERROR:   state_next = S_SQA;
                        MODE_TSYS:              state_next = S_TSH;
                        default:                state_next = S_NORM;
                    endcase
                end
            end
            S_SQA:    state_next = S_SQB;
            S_SQB:    state_next = S_SQC;
            S_SQC:    state_next = S_NORM;
            S_TSH:
            begin
                if ((to_reg | tn_reg) < 32'h0001_0000) state_next = S_T3A;
            end
            S_T3A:    state_next = S_T3B;
            S_T3B:    state_next = S_T3C;
            S_T3C:    state_next = S_T3D;
            S_T3D:    state_next = S_T3E;
            S_T3E:    state_next = S_NORM;
            S_NORM:
            begin
                if (ab_or == 64'd0) state_next = S_BLEND;
                else if (ab_or[63:31] == 33'd0) state_next = S_DIV;
            end
            S_DIV:    state_next = S_DIVW;
            S_DIVW:   if (itu_rsp.done) state_next = S_BLEND;
            S_BLEND:
            begin
                if (avg_mode != MODE_SUM) state_next = S_BLEND2;
                else if (it_reg.last) state_next = S_MSQ;
                else state_next = S_OUT;
            end
            S_BLEND2:
            begin
                if (avg_mode == MODE_ERROR || it_reg.last) state_next = S_MSQ;
                else state_next = S_OUT;
            end
            S_MSQ:    state_next = S_MS0;
            S_MS0:    state_next = S_MS1;
            S_MS1:    state_next = S_MS2;
            S_MS2:    state_next = S_MS3;
            S_MS3:    state_next = (phase_reg == PH_TOLD) ? S_MSQ : S_ROOT;
            S_ROOT:   state_next = S_ROOTW;
            S_ROOTW:
            begin
                if (itu_rsp.done)
                begin
                    if (phase_reg == PH_ERR && it_reg.last) state_next = S_MSQ;
                    else state_next = S_OUT;
                end
            end
            S_OUT:    if (out_free) state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    // Datapath and register updates per state.
    always_comb
    begin
        it_next      = it_reg;
        old_next     = old_reg;
        eo_next      = eo_reg;
        a_next       = a_reg;
        b_next       = b_reg;
        f_next       = f_reg;
        to_next      = to_reg;
        tn_next      = tn_reg;
        p_next       = p_reg;
        acc_next     = acc_reg;
        phase_next   = phase_reg;
        vout_next    = vout_reg;
        eout_next    = eout_reg;
        status_next  = status_reg;
        done_next    = done_reg;
        cnt_ch_next  = cnt_ch_reg;
        tsys_next    = tsys_reg;
        time_next    = time_reg;
        count_next   = count_reg;
        skip_next    = skip_reg;
        m_valid_next = m_valid_reg && !m_axis_tready;
        m_data_next  = m_data_reg;
        m_user_next  = m_user_reg;
        m_last_next  = m_last_reg;
        q_ready      = 1'b0;
        av_we        = 1'b0;
        er_we        = 1'b0;
        av_wd        = it_reg.sample_value;
        er_wd        = it_reg.sample_error;
        mul_a        = 32'd0;
        mul_b        = 32'd0;
        itu_req      = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                q_ready = 1'b1;
                if (q_valid) it_next = q_item;
            end
            S_READ:
            begin
            end
            S_CHECK:
            begin
                old_next    = rd_av_reg;
                eo_next     = rd_er_reg;
                vout_next   = 32'd0;
                eout_next   = 32'd0;
                done_next   = it_reg.last;
                status_next = ST_OK;
                if (it_reg.outside)
                begin
                    status_next = ST_SKIPPED;
                    done_next   = 1'b0;
                end
                else if (it_reg.start_new)
                begin
                    av_we       = 1'b1;
                    er_we       = 1'b1;
                    cnt_ch_next = it_reg.scan_channels;
                    skip_next   = 1'b0;
                    vout_next   = it_reg.sample_value;
                    eout_next   = it_reg.sample_error;
                    if (it_reg.last)
                    begin
                        tsys_next  = it_reg.scan_tsys;
                        time_next  = it_reg.scan_int_time;
                        count_next = 16'd1;
                    end
                end
                else if (skip_reg)
                begin
                    status_next = ST_SKIPPED;
                    if (it_reg.last) skip_next = 1'b0;
                end
                else if (chk_status != ST_OK)
                begin
                    status_next = chk_status;
                    if (!it_reg.last) skip_next = 1'b1;
                end
                else
                begin
                    a_next = 64'd1;
                    b_next = 64'd1;
                    f_next = Q30_HALF;
                    case (avg_mode)
                        MODE_EQUAL: a_next = 64'(count_reg);
                        MODE_TIME:
                        begin
                            a_next = 64'(time_reg);
                            b_next = 64'(it_reg.scan_int_time);
                        end
                        MODE_TSYS:
                        begin
                            to_next = tsys_reg;
                            tn_next = it_reg.scan_tsys;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_SQA:
            begin
                mul_a = (avg_mode == MODE_RMS) ? it_reg.scan_sigma : it_reg.sample_error;
                mul_b = mul_a;
            end
            S_SQB:
            begin
                a_next = prod_reg;
                mul_a  = (avg_mode == MODE_RMS) ? it_reg.acc_sigma : eo_reg;
                mul_b  = mul_a;
            end
            S_SQC:    b_next = prod_reg;
            S_TSH:
            begin
                if ((to_reg | tn_reg) >= 32'h0080_0000)
                begin
                    to_next = to_reg >> 8;
                    tn_next = tn_reg >> 8;
                end
                else if ((to_reg | tn_reg) >= 32'h0001_0000)
                begin
                    to_next = to_reg >> 1;
                    tn_next = tn_reg >> 1;
                end
            end
            S_T3A:
            begin
                mul_a = tn_reg;
                mul_b = tn_reg;
            end
            S_T3B:
            begin
                tn_next = prod_reg[31:0];
                mul_a   = to_reg;
                mul_b   = to_reg;
            end
            S_T3C:
            begin
                to_next = prod_reg[31:0];
                mul_a   = time_reg;
                mul_b   = tn_reg;
            end
            S_T3D:
            begin
                a_next = prod_reg;
                mul_a  = it_reg.scan_int_time;
                mul_b  = to_reg;
            end
            S_T3E:    b_next = prod_reg;
            S_NORM:
            begin
                if (ab_or == 64'd0)
                begin
                    f_next = Q30_HALF;
                end
                else if (ab_or[63:39] != 25'd0)
                begin
                    a_next = a_reg >> 8;
                    b_next = b_reg >> 8;
                end
                else if (ab_or[63:31] != 33'd0)
                begin
                    a_next = a_reg >> 1;
                    b_next = b_reg >> 1;
                end
            end
            S_DIV:
            begin
                itu_req.start   = 1'b1;
                itu_req.op      = ITU_DIV;
                itu_req.arg     = (64'(b_reg[30:0]) << 30) + 64'(wsum >> 1);
                itu_req.divisor = wsum;
            end
            S_DIVW:   if (itu_rsp.done) f_next = itu_rsp.result[30:0];
            S_BLEND:
            begin
                eout_next = eo_reg;
                if (avg_mode == MODE_SUM)
                begin
                    if (sat_sum > 33'sh0_7FFF_FFFF) av_wd = 32'h7FFF_FFFF;
                    else if (sat_sum < -33'sh0_8000_0000) av_wd = 32'h8000_0000;
                    else av_wd = sat_sum[31:0];
                    av_we      = 1'b1;
                    vout_next  = av_wd;
                    phase_next = PH_TOLD;
                    acc_next   = 64'd0;
                end
                else
                begin
                    mul_a = mag;
                    mul_b = {1'b0, f_reg};
                end
            end
            S_BLEND2:
            begin
                av_wd      = blend_val[31:0];
                av_we      = 1'b1;
                vout_next  = blend_val[31:0];
                phase_next = (avg_mode == MODE_ERROR) ? PH_ERR : PH_TOLD;
                acc_next   = 64'd0;
            end
            S_MSQ:
            begin
                mul_a = sq_x;
                mul_b = sq_x;
            end
            S_MS0:    p_next = prod_reg;
            S_MS1:
            begin
                mul_a = {1'b0, g};
                mul_b = p_reg[63:32];
            end
            S_MS2:
            begin
                acc_next = acc_reg + (prod_reg << 2);
                mul_a    = {1'b0, g};
                mul_b    = p_reg[31:0];
            end
            S_MS3:
            begin
                acc_next = acc_reg + (prod_reg >> 30);
                if (phase_reg == PH_TOLD) phase_next = PH_TNEW;
            end
            S_ROOT:
            begin
                itu_req.start = 1'b1;
                itu_req.op    = ITU_SQRT;
                itu_req.arg   = acc_reg;
            end
            S_ROOTW:
            begin
                if (itu_rsp.done)
                begin
                    if (phase_reg == PH_ERR)
                    begin
                        er_wd      = itu_rsp.result;
                        er_we      = 1'b1;
                        eout_next  = itu_rsp.result;
                        phase_next = PH_TOLD;
                        acc_next   = 64'd0;
                    end
                    else
                    begin
                        tsys_next = itu_rsp.result;
                        time_next = tt[32] ? 32'hFFFF_FFFF : tt[31:0];
                        if (count_reg != 16'hFFFF) count_next = count_reg + 16'd1;
                    end
                end
            end
            S_OUT:
            begin
                if (out_free)
                begin
                    m_valid_next = 1'b1;
                    m_data_next  = {4'd0, count_reg, time_reg, tsys_reg,
                                    eout_reg, vout_reg, it_reg.channel};
                    m_user_next  = status_reg;
                    m_last_next  = done_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            cnt_ch_reg  <= 13'd0;
            tsys_reg    <= 32'd0;
            time_reg    <= 32'd0;
            count_reg   <= 16'd0;
            skip_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
            phase_reg   <= PH_ERR;
        end
        else
        begin
            state_reg   <= state_next;
            cnt_ch_reg  <= cnt_ch_next;
            tsys_reg    <= tsys_next;
            time_reg    <= time_next;
            count_reg   <= count_next;
            skip_reg    <= skip_next;
            m_valid_reg <= m_valid_next;
            phase_reg   <= phase_next;
        end
    end

    always_ff @(posedge clk)
    begin
        it_reg     <= it_next;
        old_reg    <= old_next;
        eo_reg     <= eo_next;
        a_reg      <= a_next;
        b_reg      <= b_next;
        f_reg      <= f_next;
        to_reg     <= to_next;
        tn_reg     <= tn_next;
        prod_reg   <= 64'(mul_a) * 64'(mul_b);
        p_reg      <= p_next;
        acc_reg    <= acc_next;
        vout_reg   <= vout_next;
        eout_reg   <= eout_next;
        status_reg <= status_next;
        done_reg   <= done_next;
        m_data_reg <= m_data_next;
        m_user_reg <= m_user_next;
        m_last_reg <= m_last_next;
    end

    always_ff @(posedge clk)
    begin
        rd_av_reg <= avg_mem[addr];
        rd_er_reg <= err_mem[addr];
        if (av_we) avg_mem[addr] <= av_wd;
        if (er_we) err_mem[addr] <= er_wd;
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;
    assign m_axis_tuser  = m_user_reg;
    assign m_axis_tlast  = m_last_reg;

endmodule

[hw/rtl/weighted_spectrum_accumulator.sv]
// Running weighted average of spectra in Q16.16, one channel per item. A front end takes
// items into a two-entry queue, so the input keeps flowing while the back end works; the
// back end walks each item through a sequencer built around one 32x32 multiplier, a channel
// store pair (value and error, CHANNELS deep) and a shared iterative divide/square-root
// unit. Items are processed one at a time. A start item, a skipped item or an error goes
// straight to the output; plain-sum mode adds the saturating sum; the other modes add the
// weight products (plus normalizing shifts of the temperatures in tsys mode), weight
// normalization and the divide, then the blend; when both weights are zero the divide is
// skipped. Error-weighted mode adds a square root for the new channel error, and the last
// channel of a scan adds the system temperature root. The divider and root unit is the
// limiting resource. Results leave through an output register, so the next item starts
// while a result waits to be taken. The store has no clearing pass: the first scan after
// reset must be a start scan.
module weighted_spectrum_accumulator
    import wsa_pkg::*;
#(
    parameter int CHANNELS = 4096
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_we,
    input  logic [2:0]   cfg_wdata,      // avg_mode
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // channel[11:0], sample_value[43:12], sample_error[75:44], scan_channels[88:76],
    // scan_tsys[120:89], scan_int_time[152:121], scan_sigma[184:153],
    // acc_sigma[216:185], zero fill above
    input  logic [223:0] s_axis_tdata,
    input  logic [0:0]   s_axis_tuser,   // start_new
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // out_channel[11:0], avg_value[43:12], avg_error[75:44], avg_tsys[107:76],
    // avg_int_time[139:108], scans_added[155:140], zero fill above
    output logic [159:0] m_axis_tdata,
    output logic [2:0]   m_axis_tuser,   // status
    output logic         m_axis_tlast    // scan_done
);

    logic     [2:0] avg_mode_reg;
    logic     [2:0] avg_mode_next;
    logic           q_valid;
    logic           q_ready;
    item_t          q_item;
    itu_req_t       itu_req;
    itu_rsp_t       itu_rsp;

    // The mode must only be written while the block is idle; the block does not enforce it.
    assign avg_mode_next = cfg_we ? cfg_wdata : avg_mode_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            avg_mode_reg <= MODE_SUM;
        end
        else
        begin
            avg_mode_reg <= avg_mode_next;
        end
    end

    // Front end: unpacks, classifies (last channel, outside the scan, store index) and queues.
    wsa_front #(
        .CHANNELS (CHANNELS)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .q_valid       (q_valid),
        .q_ready       (q_ready),
        .q_item        (q_item)
    );

    // Back end: the per-item sequencer, the stores and the scan registers.
    wsa_back #(
        .CHANNELS (CHANNELS)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .avg_mode      (avg_mode_reg),
        .q_valid       (q_valid),
        .q_ready       (q_ready),
        .q_item        (q_item),
        .itu_req       (itu_req),
        .itu_rsp       (itu_rsp),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    // Shared divide and square-root unit, one result bit per cycle.
    wsa_itu u_itu (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (itu_req),
        .rsp   (itu_rsp)
    );

endmodule

[hw/rtl/wsa_checker.sv]
module wsa_checker
    import wsa_pkg::*;
(
    input logic         clk,
    input logic         rst_n,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [159:0] m_axis_tdata,
    input logic [2:0]   m_axis_tuser,
    input logic         m_axis_tlast
);

    // A stalled result holds still.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
            && $stable(m_axis_tlast))
        else $error("result changed while stalled");

    // An error or skipped item reports a zero value and a zero error.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser != ST_OK |-> m_axis_tdata[75:12] == 64'd0)
        else $error("nonzero data on error result");

    // A successful last channel always leaves at least one scan in the average.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tlast && m_axis_tuser == ST_OK |->
            m_axis_tdata[155:140] != 16'd0)
        else $error("scan count zero after completed scan");

    // No result can be pending right after reset.
    assert property (@(posedge clk)
        $rose(rst_n) |-> !m_axis_tvalid)
        else $error("result valid out of reset");

endmodule

bind weighted_spectrum_accumulator wsa_checker u_wsa_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);

[bench/tb_top.sv]
module tb_top;
    import wsa_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // The mode register is three bits wide; the two top codes have no name in the
    // package and fall back to an unweighted average.
    localparam logic [2:0] MODE_SPARE6 = 3'd6;
    localparam logic [2:0] MODE_SPARE7 = 3'd7;
    localparam int         CYCLE_LIMIT = 4000000;
    localparam int         DRAIN_CYCLES = 400;

    // One input item, field by field.
    typedef struct {
        bit        start_new;
        bit [11:0] channel;
        bit [31:0] sample_value;
        bit [31:0] sample_error;
        bit [12:0] scan_channels;
        bit [31:0] scan_tsys;
        bit [31:0] scan_int_time;
        bit [31:0] scan_sigma;
        bit [31:0] acc_sigma;
    } spec_item_t;

    // One result item, field by field.
    typedef struct {
        bit [11:0] channel;
        bit [31:0] avg_value;
        bit [31:0] avg_error;
        status_t   status;
        bit [31:0] avg_tsys;
        bit [31:0] avg_int_time;
        bit [15:0] scans_added;
        bit        scan_done;
    } avg_result_t;

    // The accumulator's expected behavior. Every accepted input item is folded into a
    // private copy of the channel stores and the scan registers, and the resulting
    // output item is queued until the block delivers its own.
    class avg_scoreboard;
        bit [31:0]   avg_mem [4096];
        bit [31:0]   err_mem [4096];
        bit          written [4096];
        bit [12:0]   chan_count;
        bit [31:0]   tsys_acc;
        bit [31:0]   time_acc;
        bit [15:0]   scans_acc;
        bit          skipping;
        bit [2:0]    mode;
        avg_result_t pending_q[$];
        int          mismatches;

        function bit [31:0] isqrt(bit [63:0] x);
            bit [63:0] r;
            bit [63:0] t;
            r = 0;
            for (int i = 31; i >= 0; i--)
            begin
                t = r | (64'd1 << i);
                if (t * t <= x)
                    r = t;
            end
            return r[31:0];
        endfunction

        // floor(g * p / 2^30), g at most 2^30.
        function bit [63:0] scale30(bit [63:0] g, bit [63:0] p);
            return ((g * (p >> 32)) << 2) + ((g * (p & 64'hFFFF_FFFF)) >> 30);
        endfunction

        // Share of the new weight, w_new / (w_old + w_new), as unsigned Q2.30.
        function bit [63:0] new_share(bit [63:0] w_old, bit [63:0] w_new);
            bit [63:0] s;
            if (w_old == 0 && w_new == 0)
                return 64'd1 << 29;
            while (w_old >= (64'd1 << 31) || w_new >= (64'd1 << 31))
            begin
                w_old >>= 1;
                w_new >>= 1;
            end
            s = w_old + w_new;
            return ((w_new << 30) + s / 2) / s;
        endfunction

        function void note_item(spec_item_t it);
            avg_result_t res;
            bit          last;
            bit [11:0]   idx;
            bit [31:0]   eo;
            bit [63:0]   wa;
            bit [63:0]   wb;
            bit [63:0]   f;
            bit [63:0]   to;
            bit [63:0]   tn;
            bit [63:0]   t2;
            bit [63:0]   tt;
            bit [63:0]   mag;
            bit [63:0]   r;
            longint      old_v;
            longint      new_v;
            longint      d;
            longint      s;
            status_t     st;

            idx  = it.channel;
            last = ({1'b0, it.channel} + 13'd1 == it.scan_channels);
            st   = ST_OK;
            res.avg_value = 0;
            res.avg_error = 0;
            res.scan_done = 0;
            if ({1'b0, it.channel} >= it.scan_channels)
            begin
                st = ST_SKIPPED;
            end
            else if (it.start_new)
            begin
                avg_mem[idx] = it.sample_value;
                err_mem[idx] = it.sample_error;
                written[idx] = 1;
                chan_count   = it.scan_channels;
                skipping     = 0;
                if (last)
                begin
                    tsys_acc  = it.scan_tsys;
                    time_acc  = it.scan_int_time;
                    scans_acc = 1;
                end
                res.avg_value = it.sample_value;
                res.avg_error = it.sample_error;
                res.scan_done = last;
            end
            else if (skipping)
            begin
                st = ST_SKIPPED;
                if (last)
                    skipping = 0;
                res.scan_done = last;
            end
            else
            begin
                eo = err_mem[idx];
                if (it.scan_channels != chan_count)
                    st = ST_MISMATCH;
                else if (mode == MODE_RMS && (it.acc_sigma == 0 || it.scan_sigma == 0))
                    st = ST_ZERO_ERR;
                else if (mode == MODE_TSYS && (tsys_acc == 0 || it.scan_tsys == 0))
                    st = ST_ZERO_TSYS;
                else if (mode == MODE_ERROR && (eo == 0 || it.sample_error == 0))
                    st = ST_ZERO_ERR;

                if (st != ST_OK)
                begin
                    if (!last)
                        skipping = 1;
                    res.scan_done = last;
                end
                else
                begin
                    wa = 1;
                    wb = 1;
                    old_v = longint'($signed(avg_mem[idx]));
                    new_v = longint'($signed(it.sample_value));
                    case (mode)
                        MODE_EQUAL:
                        begin
                            wa = 64'(scans_acc);
                        end
                        MODE_RMS:
                        begin
                            wa = 64'(it.scan_sigma) * 64'(it.scan_sigma);
                            wb = 64'(it.acc_sigma) * 64'(it.acc_sigma);
                        end
                        MODE_TSYS:
                        begin
                            // Both temperatures are narrowed together to 16 bits.
                            to = 64'(tsys_acc);
                            tn = 64'(it.scan_tsys);
                            while (to >= 65536 || tn >= 65536)
                            begin
                                to >>= 1;
                                tn >>= 1;
                            end
                            wa = 64'(time_acc) * (tn * tn);
                            wb = 64'(it.scan_int_time) * (to * to);
                        end
                        MODE_TIME:
                        begin
                            wa = 64'(time_acc);
                            wb = 64'(it.scan_int_time);
                        end
                        MODE_ERROR:
                        begin
                            wa = 64'(it.sample_error) * 64'(it.sample_error);
                            wb = 64'(eo) * 64'(eo);
                        end
                        default:
                        begin
                        end
                    endcase
                    f = (mode == MODE_SUM) ? (64'd1 << 29) : new_share(wa, wb);

                    if (mode == MODE_SUM)
                    begin
                        // Plain sum saturates at the Q16.16 limits.
                        s = old_v + new_v;
                        if (s > 64'sd2147483647)
                            s = 64'sd2147483647;
                        if (s < -64'sd2147483648)
                            s = -64'sd2147483648;
                        avg_mem[idx] = s[31:0];
                    end
                    else
                    begin
                        // The step toward the new sample rounds half away from zero.
                        d   = new_v - old_v;
                        mag = (d < 0) ? -d : d;
                        r   = (mag * f + (64'd1 << 29)) >> 30;
                        s   = (d < 0) ? old_v - longint'(r) : old_v + longint'(r);
                        avg_mem[idx] = s[31:0];
                    end
                    if (mode == MODE_ERROR)
                        err_mem[idx] = isqrt(scale30((64'd1 << 30) - f, 64'(eo) * 64'(eo)));

                    if (last)
                    begin
                        t2 = scale30((64'd1 << 30) - f, 64'(tsys_acc) * 64'(tsys_acc))
                           + scale30(f, 64'(it.scan_tsys) * 64'(it.scan_tsys));
                        tt = 64'(time_acc) + 64'(it.scan_int_time);
                        tsys_acc = isqrt(t2);
                        time_acc = (tt > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : tt[31:0];
                        if (scans_acc != 16'hFFFF)
                            scans_acc++;
                    end
                    res.avg_value = avg_mem[idx];
                    res.avg_error = err_mem[idx];
                    res.scan_done = last;
                end
            end
            res.channel      = it.channel;
            res.status       = st;
            res.avg_tsys     = tsys_acc;
            res.avg_int_time = time_acc;
            res.scans_added  = scans_acc;
            pending_q.push_back(res);
        endfunction

        function void check_result(avg_result_t got);
            avg_result_t want;
            if (pending_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result item: channel %0d", got.channel);
                return;
            end
            want = pending_q.pop_front();
            if (got != want)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("result mismatch on channel %0d:", want.channel);
                    $display("  expected ch %0d val %h err %h st %0d tsys %h time %h n %0d done %0d",
                             want.channel, want.avg_value, want.avg_error, want.status,
                             want.avg_tsys, want.avg_int_time, want.scans_added,
                             want.scan_done);
                    $display("  actual   ch %0d val %h err %h st %0d tsys %h time %h n %0d done %0d",
                             got.channel, got.avg_value, got.avg_error, got.status,
                             got.avg_tsys, got.avg_int_time, got.scans_added,
                             got.scan_done);
                end
            end
        endfunction
    endclass

    logic         clk;
    logic         rst_n;
    logic         cfg_we;
    logic [2:0]   cfg_wdata;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [223:0] s_axis_tdata;
    logic [0:0]   s_axis_tuser;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [159:0] m_axis_tdata;
    logic [2:0]   m_axis_tuser;
    logic         m_axis_tlast;

    avg_scoreboard sb;
    int            items_sent;
    int            send_idle_pct;
    int            recv_idle_pct;
    int            cycle_count;

    weighted_spectrum_accumulator u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial
    begin
        clk = 0;
    end

    always
    begin
        #6 clk = 1;
        #6 clk = 0;
    end

    // The result side stalls at random with the current rate, and every accepted result
    // item is unpacked and handed to the scoreboard.
    always @(posedge clk)
    begin
        avg_result_t got;
        m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got.channel      = m_axis_tdata[11:0];
            got.avg_value    = m_axis_tdata[43:12];
            got.avg_error    = m_axis_tdata[75:44];
            got.avg_tsys     = m_axis_tdata[107:76];
            got.avg_int_time = m_axis_tdata[139:108];
            got.scans_added  = m_axis_tdata[155:140];
            got.status       = status_t'(m_axis_tuser);
            got.scan_done    = m_axis_tlast;
            sb.check_result(got);
        end
    end

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    function automatic bit [31:0] pick_word();
        case ($urandom_range(9))
            0:       return 32'h0000_0000;
            1:       return 32'hFFFF_FFFF;
            2:       return 32'h8000_0000;
            3:       return 32'h7FFF_FFFF;
            4, 5:    return $urandom_range(32'h0010_0000, 1);
            default: return $urandom;
        endcase
    endfunction

    function automatic spec_item_t make_item(bit st, int ch, bit [31:0] sv, bit [31:0] se,
                                             int nch, bit [31:0] ts, bit [31:0] ti,
                                             bit [31:0] ss, bit [31:0] as);
        spec_item_t it;
        it.start_new     = st;
        it.channel       = 12'(ch);
        it.sample_value  = sv;
        it.sample_error  = se;
        it.scan_channels = 13'(nch);
        it.scan_tsys     = ts;
        it.scan_int_time = ti;
        it.scan_sigma    = ss;
        it.acc_sigma     = as;
        return it;
    endfunction

    // Sends one item and notes it once accepted. The valid line is left high so that a
    // following item can go out back to back; stop_sending lowers it.
    task automatic send_item(spec_item_t it);
        // A store entry that was never written must not be read: such an item is moved
        // to channel zero, which the first start scan always fills.
        if (!it.start_new && {1'b0, it.channel} < it.scan_channels && !sb.skipping
            && !sb.written[it.channel])
            it.channel = 0;
        if (items_sent < 333)
        begin
            send_idle_pct = 15;
            recv_idle_pct = 87;
        end
        else if (items_sent < 666)
        begin
            send_idle_pct = 87;
            recv_idle_pct = 15;
        end
        else
        begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
        end
        if ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < send_idle_pct);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= it.start_new;
        s_axis_tdata  <= {7'd0, it.acc_sigma, it.scan_sigma, it.scan_int_time, it.scan_tsys,
                          it.scan_channels, it.sample_error, it.sample_value, it.channel};
        do
            @(posedge clk);
        while (!s_axis_tready);
        sb.note_item(it);
        items_sent++;
    endtask

    task automatic stop_sending();
        s_axis_tvalid <= 1'b0;
    endtask

    // The mode changes only once every outstanding result has come back.
    task automatic write_mode(bit [2:0] m);
        stop_sending();
        while (sb.pending_q.size() != 0)
            @(posedge clk);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= m;
        @(posedge clk);
        cfg_we    <= 1'b0;
        sb.mode = m;
    endtask

    // One scan with random content. Most scans are well formed; some carry a wrong
    // channel count, stray items, or stop early.
    task automatic random_scan();
        bit         st;
        int         nch;
        bit [31:0]  ts;
        bit [31:0]  ti;
        bit [31:0]  ss;
        bit [31:0]  as;
        spec_item_t it;

        st = (sb.chan_count == 0) || ($urandom_range(99) < 20);
        if (st)
            nch = ($urandom_range(19) == 0) ? $urandom_range(40, 9) : $urandom_range(6, 1);
        else if ($urandom_range(99) < 85)
            nch = sb.chan_count;
        else
            nch = $urandom_range(8, 1);
        ts = pick_word();
        ti = pick_word();
        ss = pick_word();
        as = pick_word();
        for (int ch = 0; ch < nch; ch++)
        begin
            if ($urandom_range(99) < 3)
            begin
                // Stray item: never a start, any channel count including oversized ones.
                it = make_item(1'b0, $urandom_range(4095), pick_word(), pick_word(),
                               $urandom_range(8191), pick_word(), pick_word(), pick_word(),
                               pick_word());
                send_item(it);
            end
            if (ch > 0 && $urandom_range(99) < 2)
                break;
            send_item(make_item(st, ch, pick_word(), pick_word(), nch, ts, ti, ss, as));
        end
    endtask

    initial
    begin
        bit [2:0] phase_modes [10];

        sb = new();
        phase_modes = '{MODE_EQUAL, MODE_RMS, MODE_TSYS, MODE_TIME, MODE_ERROR,
                        MODE_SPARE6, MODE_SPARE7, MODE_SUM, MODE_ERROR, MODE_TSYS};
        items_sent    = 0;
        cycle_count   = 0;
        send_idle_pct = 15;
        recv_idle_pct = 87;
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_wdata     = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        m_axis_tready = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part in plain-sum mode, the reset mode. A first scan is a start scan.
        send_item(make_item(1, 0, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 1, 32'hFFFF_FFFF,
                            32'hFFFF_FFFF, 0, 0));
        // Largest scan: its only item here is the top channel, which is its last.
        send_item(make_item(1, 4095, 32'h8000_0000, 32'h0000_0001, 4096, 32'h0001_0000,
                            32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
        send_item(make_item(0, 4095, 32'h8000_0000, 32'h0000_0001, 4096, 32'h0001_0000,
                            32'hFFFF_FFFF, 1, 1));
        // A zero channel count and a channel beyond the scan are both outside it.
        send_item(make_item(0, 0, 32'h1234_5678, 1, 0, 1, 1, 1, 1));
        send_item(make_item(1, 7, 32'h1234_5678, 1, 5, 1, 1, 1, 1));
        // Two-channel start scan, then positive and negative sum saturation.
        send_item(make_item(1, 0, 32'h7FFF_FFFF, 32'h0001_0000, 2, 32'h0002_0000,
                            32'h0000_8000, 1, 1));
        send_item(make_item(1, 1, 32'h8000_0000, 32'h0001_0000, 2, 32'h0002_0000,
                            32'h0000_8000, 1, 1));
        send_item(make_item(0, 0, 32'h7FFF_FFFF, 32'h0001_0000, 2, 32'h0003_0000,
                            32'hFFFF_FFFF, 1, 1));
        send_item(make_item(0, 1, 32'h8000_0000, 32'h0001_0000, 2, 32'h0003_0000,
                            32'hFFFF_FFFF, 1, 1));
        // Channel count mismatch: the rest of the scan is skipped through its last item.
        send_item(make_item(0, 0, 32'h0000_0001, 1, 3, 1, 1, 1, 1));
        send_item(make_item(0, 1, 32'h0000_0001, 1, 3, 1, 1, 1, 1));
        send_item(make_item(0, 2, 32'h0000_0001, 1, 3, 1, 1, 1, 1));
        // Oversized scan count: the channel indexes the store, the last is never reached.
        send_item(make_item(0, 1, 32'hFFFF_FFFF, 1, 8191, 1, 1, 1, 1));
        // Zero time on both sides gives two zero weights in time mode.
        write_mode(MODE_TIME);
        send_item(make_item(1, 0, 32'h0001_0000, 32'h0000_0100, 1, 32'h0001_0000, 0, 1, 1));
        send_item(make_item(0, 0, 32'h0003_0000, 32'h0000_0100, 1, 32'h0001_0000, 0, 1, 1));
        // Zero channel error in error mode on a one-channel scan errors on the last item.
        write_mode(MODE_ERROR);
        send_item(make_item(0, 0, 32'h0003_0000, 0, 1, 32'h0001_0000, 1, 1, 1));
        // Zero system temperature in tsys mode.
        write_mode(MODE_TSYS);
        send_item(make_item(0, 0, 32'h0003_0000, 1, 1, 0, 1, 1, 1));

        // Random part, one phase per mode setting.
        foreach (phase_modes[p])
        begin
            int target;
            write_mode(phase_modes[p]);
            target = items_sent + 100;
            while (items_sent < target)
                random_scan();
        end
        stop_sending();

        while (sb.pending_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.mismatches == 0 && sb.pending_q.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
